### rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PRTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prtt assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PRTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prtt assertion failed");

`endif

### rtl/prtt_pkg.sv
// shared types and constants of the peer request throttle table
package prtt_pkg;

  localparam int          SLOT_COUNT_DEF = 8;
  localparam logic [31:0] BCAST_ID       = 32'hFFFF_FFFF;
  localparam logic [15:0] THROTTLE_RESET = 16'd60;

  // register index, taken from paddr[2]
  localparam logic REG_OWN_NODE_ID   = 1'b0;
  localparam logic REG_THROTTLE_SECS = 1'b1;

  typedef enum logic [2:0] {
    OUT_INVALID   = 3'd0,
    OUT_THROTTLED = 3'd1,
    OUT_HIT       = 3'd2,
    OUT_FREE      = 3'd3,
    OUT_EVICT     = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } prtt_state_t;

  typedef struct packed {
    logic [31:0] peer;
    logic [31:0] stamp;
  } prtt_entry_t;

endpackage

### rtl/peer_request_throttle_table.sv
// top level: per-peer request throttle table with oldest-slot eviction
// an invalid destination is answered from the result registers without a walk; a
//   walked request reads slots in ST_SCAN, compares each returned entry, stops at a
//   match or the last slot, writes back in ST_DONE and then shows its registered result
// throughput: busy blocks the next start during a walk (one slot read per cycle, one
//   compare stage); invalid destinations can follow back to back
// reset: own_node_id 0, throttle_secs 60, all slots free; the receiver cannot stall
module peer_request_throttle_table
  import prtt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_dest_node,
  input  logic [31:0] in_now_secs,
  // result channel, one-cycle strobe
  output logic        out_strobe,
  output logic        out_send_request,
  output logic [2:0]  out_outcome,
  output logic [2:0]  out_slot_used,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] own_id_r;
  logic [15:0] throttle_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r   <= '0;
      throttle_r <= THROTTLE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_OWN_NODE_ID:   own_id_r   <= pwdata;
        REG_THROTTLE_SECS: throttle_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OWN_NODE_ID:   prdata = own_id_r;
      REG_THROTTLE_SECS: prdata = {16'b0, throttle_r};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers of the request walk
  // ---------------------------------------------------------------------------
  prtt_state_t      state_r, state_nxt;
  logic [31:0]      dest_r, dest_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;     // next slot to read
  logic             rd_go_r, rd_go_nxt;       // reads still to issue
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;   // slot whose data is on the read port
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             have_free_r, have_free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [31:0]      old_age_r, old_age_nxt;
  logic [IDX_W-1:0] old_idx_r, old_idx_nxt;
  logic             done_r, done_nxt;         // decision taken, walk over
  outcome_t         res_out_r, res_out_nxt;
  logic [IDX_W-1:0] res_slot_r, res_slot_nxt;
  logic             res_wr_r, res_wr_nxt;     // refresh or allocate on write-back

  // result registers
  logic             out_strobe_r, out_strobe_nxt;
  logic             out_send_r, out_send_nxt;
  outcome_t         out_out_r, out_out_nxt;
  logic [2:0]       out_slot_r, out_slot_nxt;

  // slot memory ports
  logic             rd_en;
  prtt_entry_t      rd_data;
  logic             wr_en;
  prtt_entry_t      wr_data;

  logic             accept;
  logic             dest_bad;
  logic [31:0]      age;
  logic             hit;

  assign accept   = start && !busy;
  assign dest_bad = (in_dest_node == '0) || (in_dest_node == own_id_r) ||
                    (in_dest_node == BCAST_ID);
  assign age      = now_r - rd_data.stamp;   // wraps modulo 2^32
  assign hit      = cmp_vld_r && (rd_data.peer == dest_r);

  assign busy     = (state_r != ST_IDLE);
  assign rd_en    = (state_r == ST_SCAN) && rd_go_r;
  assign wr_en    = (state_r == ST_DONE) && res_wr_r;
  assign wr_data  = '{peer: dest_r, stamp: now_r};

  prtt_slot_ram #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (res_slot_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !dest_bad) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done_nxt) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and result
  // ---------------------------------------------------------------------------
  always_comb begin
    dest_nxt      = dest_r;
    now_nxt       = now_r;
    rd_idx_nxt    = rd_idx_r;
    rd_go_nxt     = rd_go_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = 1'b0;
    have_free_nxt = have_free_r;
    free_idx_nxt  = free_idx_r;
    old_age_nxt   = old_age_r;
    old_idx_nxt   = old_idx_r;
    done_nxt      = 1'b0;
    res_out_nxt   = res_out_r;
    res_slot_nxt  = res_slot_r;
    res_wr_nxt    = res_wr_r;
    out_strobe_nxt = 1'b0;
    out_send_nxt  = out_send_r;
    out_out_nxt   = out_out_r;
    out_slot_nxt  = out_slot_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          dest_nxt      = in_dest_node;
          now_nxt       = in_now_secs;
          rd_idx_nxt    = '0;
          rd_go_nxt     = 1'b1;
          have_free_nxt = 1'b0;
          free_idx_nxt  = '0;
          old_age_nxt   = '0;
          old_idx_nxt   = '0;
          // rejected destination answers at once, table untouched
          if (dest_bad) begin
            out_strobe_nxt = 1'b1;
            out_send_nxt   = 1'b0;
            out_out_nxt    = OUT_INVALID;
            out_slot_nxt   = '0;
          end
        end
      end

      ST_SCAN: begin
        // read side: one slot per cycle
        if (rd_go_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
          if (rd_idx_r == LAST_IDX) begin
            rd_go_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
          end
        end
        // compare side: slot data returned from the memory
        if (hit) begin
          done_nxt     = 1'b1;
          res_slot_nxt = cmp_idx_r;
          if (age < {16'b0, throttle_r}) begin
            res_out_nxt = OUT_THROTTLED;
            res_wr_nxt  = 1'b0;
          end else begin
            res_out_nxt = OUT_HIT;
            res_wr_nxt  = 1'b1;
          end
        end else if (cmp_vld_r) begin
          if (rd_data.peer == '0 && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_idx_nxt  = cmp_idx_r;
          end
          // strict compare keeps the lowest index on equal ages
          if (age > old_age_r) begin
            old_age_nxt = age;
            old_idx_nxt = cmp_idx_r;
          end
          if (cmp_idx_r == LAST_IDX) begin
            done_nxt   = 1'b1;
            res_wr_nxt = 1'b1;
            if (have_free_nxt) begin
              res_out_nxt  = OUT_FREE;
              res_slot_nxt = free_idx_nxt;
            end else begin
              res_out_nxt  = OUT_EVICT;
              res_slot_nxt = old_idx_nxt;
            end
          end
        end
      end

      ST_DONE: begin
        // write-back happens in this cycle, result shows in the next
        out_strobe_nxt = 1'b1;
        out_send_nxt   = res_wr_r;
        out_out_nxt    = res_out_r;
        out_slot_nxt   = 3'(res_slot_r);
      end

      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_go_r      <= 1'b0;
      cmp_vld_r    <= 1'b0;
      done_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_go_r      <= rd_go_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      done_r       <= done_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    dest_r      <= dest_nxt;
    now_r       <= now_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    have_free_r <= have_free_nxt;
    free_idx_r  <= free_idx_nxt;
    old_age_r   <= old_age_nxt;
    old_idx_r   <= old_idx_nxt;
    res_out_r   <= res_out_nxt;
    res_slot_r  <= res_slot_nxt;
    res_wr_r    <= res_wr_nxt;
    out_send_r  <= out_send_nxt;
    out_out_r   <= out_out_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  assign out_strobe       = out_strobe_r && !done_r;
  assign out_send_request = out_send_r;
  assign out_outcome      = out_out_r;
  assign out_slot_used    = out_slot_r;

endmodule

### rtl/prtt_slot_ram.sv
// slot memory with a registered read and per-entry valid bits
module prtt_slot_ram
  import prtt_pkg::*;
#(
  parameter int  SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  prtt_entry_t      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output prtt_entry_t      rd_data
);

  prtt_entry_t            mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  valid_r;
  prtt_entry_t            rd_q_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  // never-written slot reads as free with time zero
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

### rtl/prtt_checker.sv
// port-level checker for the peer request throttle table, bound to the top level
`include "assert_macros.svh"

module prtt_checker
  import prtt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_send_request,
  input logic [2:0] out_outcome,
  input logic [2:0] out_slot_used
);

  // a sent request is a hit, a new slot or an eviction
  `PRTT_ASSERT_IMP(a_send_code, out_strobe && out_send_request, out_outcome == OUT_HIT || out_outcome == OUT_FREE || out_outcome == OUT_EVICT)

  // a held-back request is rejected or throttled
  `PRTT_ASSERT_IMP(a_hold_code, out_strobe && !out_send_request, out_outcome == OUT_INVALID || out_outcome == OUT_THROTTLED)

  // a rejected destination names no slot
  `PRTT_ASSERT_IMP(a_invalid_slot, out_strobe && out_outcome == OUT_INVALID, out_slot_used == 3'd0)

  // every accepted request either answers next cycle or keeps the block busy
  `PRTT_ASSERT_NXT(a_accept_follow, start && !busy, out_strobe || busy)

  // the walk ends with its result transfer
  `PRTT_ASSERT_IMP(a_walk_result, $fell(busy), out_strobe)

endmodule

bind peer_request_throttle_table prtt_checker u_prtt_checker (.*);

### bench/tb_peer_request_throttle_table.sv
// testbench for the peer request throttle table: directed and random requests against a table model
`timescale 1ns / 1ps

module tb_peer_request_throttle_table;
  import prtt_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;

  // one expected result per accepted request
  typedef struct packed {
    logic     send;
    outcome_t outcome;
    logic [2:0] slot;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_dest_node;
  logic [31:0] in_now_secs;
  logic        out_strobe;
  logic        out_send_request;
  logic [2:0]  out_outcome;
  logic [2:0]  out_slot_used;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block: registers and the peer/time table
  logic [31:0] own_id;
  logic [15:0] throttle_limit;
  logic [31:0] peer_tab  [SLOTS];
  logic [31:0] stamp_tab [SLOTS];

  verdict_t pending_q [$];

  int error_count;
  int req_count;
  int result_count;
  int reg_write_count;
  int outcome_seen [5];
  int lead_gap;
  int burst_left;

  always #4 clk = ~clk;

  peer_request_throttle_table #(
    .SLOT_COUNT(SLOTS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_dest_node     (in_dest_node),
    .in_now_secs      (in_now_secs),
    .out_strobe       (out_strobe),
    .out_send_request (out_send_request),
    .out_outcome      (out_outcome),
    .out_slot_used    (out_slot_used),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  // table lookup for one request; updates the shadow table like the block does
  function automatic verdict_t predict_request(logic [31:0] dest, logic [31:0] now_s);
    verdict_t v;
    logic [31:0] age;
    logic [31:0] max_age;
    int free_idx;
    int oldest_idx;
    int pick;
    int i;
    v.send     = 1'b0;
    v.outcome  = OUT_INVALID;
    v.slot     = '0;
    free_idx   = -1;
    oldest_idx = 0;
    max_age    = '0;
    // zero, own id and broadcast never touch the table
    if (dest == '0 || dest == own_id || dest == BCAST_ID) begin
      return v;
    end
    for (i = 0; i < SLOTS; i++) begin
      // wrapping age, so a stamp just before the time wrap still looks recent
      age = now_s - stamp_tab[i];
      if (peer_tab[i] == dest) begin
        v.slot = 3'(i);
        if (age < {16'd0, throttle_limit}) begin
          v.outcome = OUT_THROTTLED;
        end else begin
          stamp_tab[i] = now_s;
          v.send       = 1'b1;
          v.outcome    = OUT_HIT;
        end
        return v;
      end
      if (peer_tab[i] == '0 && free_idx < 0) begin
        free_idx = i;
      end
      // strict compare keeps the lowest index on equal ages
      if (age > max_age) begin
        max_age    = age;
        oldest_idx = i;
      end
    end
    if (free_idx >= 0) begin
      pick      = free_idx;
      v.outcome = OUT_FREE;
    end else begin
      pick      = oldest_idx;
      v.outcome = OUT_EVICT;
    end
    peer_tab[pick]  = dest;
    stamp_tab[pick] = now_s;
    v.send          = 1'b1;
    v.slot          = 3'(pick);
    return v;
  endfunction

  // result checker: the block cannot be held off, so every strobe is a transfer
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      result_count++;
      if (pending_q.size() == 0) begin
        report_error($sformatf("result %0d with nothing pending: send=%0d outcome=%0d slot=%0d",
                               result_count, out_send_request, out_outcome, out_slot_used));
      end else begin
        want = pending_q.pop_front();
        outcome_seen[int'(want.outcome)]++;
        if (out_send_request !== want.send) begin
          report_error($sformatf("result %0d send_request: expected %0d, got %0d",
                                 result_count, want.send, out_send_request));
        end
        if (out_outcome !== want.outcome) begin
          report_error($sformatf("result %0d outcome: expected %0d, got %0d",
                                 result_count, want.outcome, out_outcome));
        end
        if (out_slot_used !== want.slot) begin
          report_error($sformatf("result %0d slot_used: expected %0d, got %0d",
                                 result_count, want.slot, out_slot_used));
        end
      end
    end
  end

  // one request transfer; start stays high into the next request when no gap is drawn
  task automatic send_request(input logic [31:0] dest, input logic [31:0] now_s);
    repeat (lead_gap) @(posedge clk);
    start        <= 1'b1;
    in_dest_node <= dest;
    in_now_secs  <= now_s;
    do @(posedge clk); while (busy !== 1'b0);
    pending_q.push_back(predict_request(dest, now_s));
    req_count++;
    // gap before the next request, with occasional back-to-back bursts
    if (burst_left > 0) begin
      burst_left--;
      lead_gap = 0;
    end else begin
      lead_gap = $urandom_range(0, 5);
      if ($urandom_range(0, 19) == 0) begin
        burst_left = $urandom_range(4, 12);
      end
    end
    if (lead_gap != 0) begin
      start <= 1'b0;
    end
  endtask

  // drop start and let every outstanding request finish
  task automatic wait_idle();
    if (lead_gap == 0) begin
      start <= 1'b0;
    end
    do @(posedge clk); while (pending_q.size() != 0 || busy !== 1'b0);
  endtask

  // setup then access phase; psel is left high so transfers can run back to back
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  task automatic reg_check(input logic idx);
    logic [31:0] rd;
    logic [31:0] reg_want;
    apb_access(1'b0, {idx, 2'b00}, '0, rd);
    if (idx == REG_OWN_NODE_ID) begin
      reg_want = own_id;
    end else begin
      reg_want = {16'd0, throttle_limit};
      rd       = {16'd0, rd[15:0]};
    end
    if (rd !== reg_want) begin
      report_error($sformatf("register %0d read: expected %08h, got %08h", idx, reg_want, rd));
    end
  endtask

  // write while idle, then read the value back
  task automatic reg_write(input logic idx, input logic [31:0] value);
    logic [31:0] rd_discard;
    wait_idle();
    apb_access(1'b1, {idx, 2'b00}, value, rd_discard);
    if (idx == REG_OWN_NODE_ID) begin
      own_id = value;
    end else begin
      throttle_limit = value[15:0];
    end
    reg_write_count++;
    reg_check(idx);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_register_reset();
    reg_check(REG_OWN_NODE_ID);
    reg_check(REG_THROTTLE_SECS);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // zero and broadcast are rejected; own id is zero after reset
  task automatic test_rejected_ids();
    send_request('0, 32'd5);
    send_request(BCAST_ID, 32'd6);
  endtask

  // one peer: first request, inside the window, exactly at the window edge
  task automatic test_throttle_window();
    send_request(32'd1, 32'd0);
    send_request(32'd1, 32'd59);
    send_request(32'd1, 32'd60);
  endtask

  // fill every slot, evict the oldest, then evict with all ages equal
  task automatic test_fill_and_evict();
    int i;
    for (i = 2; i <= SLOTS; i++) begin
      send_request(32'(i), 32'd100);
    end
    send_request(32'd9, 32'd100);
    send_request(32'd10, 32'd100);
  endtask

  // ages across the 32-bit time wrap, extreme ids and times
  task automatic test_time_wrap();
    send_request(32'd3, 32'hFFFF_FFF0);
    send_request(32'd3, 32'h0000_0020);
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
  endtask

  // own id rejection, zero throttle and the widest throttle window
  task automatic test_config_extremes();
    reg_write(REG_OWN_NODE_ID, 32'hFFFF_FFFE);
    reg_write(REG_THROTTLE_SECS, 32'd0);
    send_request(32'hFFFF_FFFE, 32'd0);
    send_request(32'd4, 32'd100);
    send_request(32'd4, 32'd100);
    reg_write(REG_THROTTLE_SECS, 32'h0000_FFFF);
    send_request(32'd4, 32'd100 + 32'h0000_FFFE);
    send_request(32'd4, 32'd100 + 32'h0000_FFFF);
  endtask

  // mostly a small peer pool with short time steps, plus stray ids and time jumps
  task automatic run_traffic(input int n_req);
    logic [31:0] pool [16];
    logic [31:0] clock_s;
    logic [31:0] dest;
    int pool_size;
    int pick;
    int span;
    int i;
    pool_size = $urandom_range(5, 16);
    for (i = 0; i < 16; i++) begin
      pool[i] = $urandom();
    end
    pool[0] = 32'h0000_0001;
    pool[1] = 32'hFFFF_FFFE;
    clock_s = $urandom();
    span    = int'(throttle_limit) / 3 + 2;
    repeat (n_req) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        dest = pool[$urandom_range(0, pool_size - 1)];
      end else if (pick < 92) begin
        dest = $urandom();
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            dest = '0;
          end
          1: begin
            dest = own_id;
          end
          default: begin
            dest = BCAST_ID;
          end
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        clock_s += $urandom_range(0, span);
      end else if (pick < 95) begin
        clock_s += $urandom_range(0, 2 * int'(throttle_limit) + 4);
      end else begin
        clock_s = $urandom();
      end
      send_request(dest, clock_s);
    end
  endtask

  task automatic test_random_traffic();
    reg_write(REG_OWN_NODE_ID, $urandom());
    reg_write(REG_THROTTLE_SECS, 32'd60);
    run_traffic(190);
    reg_write(REG_OWN_NODE_ID, BCAST_ID);
    reg_write(REG_THROTTLE_SECS, 32'd0);
    run_traffic(190);
    reg_write(REG_OWN_NODE_ID, 32'h0000_0001);
    reg_write(REG_THROTTLE_SECS, 32'h0000_FFFF);
    run_traffic(190);
    reg_write(REG_OWN_NODE_ID, $urandom());
    reg_write(REG_THROTTLE_SECS, 32'd1);
    run_traffic(190);
    reg_write(REG_OWN_NODE_ID, '0);
    reg_write(REG_THROTTLE_SECS, $urandom_range(2, 300));
    run_traffic(190);
  endtask

  initial begin
    int i;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_dest_node = '0;
    in_now_secs  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    own_id         = '0;
    throttle_limit = THROTTLE_RESET;
    for (i = 0; i < SLOTS; i++) begin
      peer_tab[i]  = '0;
      stamp_tab[i] = '0;
    end
    error_count     = 0;
    req_count       = 0;
    result_count    = 0;
    reg_write_count = 0;
    lead_gap        = 1;
    burst_left      = 0;
    for (i = 0; i < 5; i++) begin
      outcome_seen[i] = 0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_register_reset();
    test_rejected_ids();
    test_throttle_window();
    test_fill_and_evict();
    test_time_wrap();
    test_config_extremes();
    test_random_traffic();

    // drain, then give a stray late strobe time to show up
    wait_idle();
    repeat (2 * SLOTS + 10) @(posedge clk);
    if (pending_q.size() != 0) begin
      report_error($sformatf("%0d results never arrived", pending_q.size()));
    end

    $display("covered %0d requests and %0d results over %0d register writes",
             req_count, result_count, reg_write_count);
    $display("outcomes: invalid %0d, throttled %0d, hit %0d, free slot %0d, evicted %0d",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
